// ----- design/bpis_pkg.sv -----
// Shared types and constants for the bloom-prefiltered ID set.
package bpis_pkg;

	localparam int ID_W          = 63;
	localparam int HASH_REG_W    = 4;
	localparam int MIN_HASH_BITS = 5;
	localparam int BYTE_SHIFT    = 3;
	localparam int ID_MASK       = 7;

	localparam logic [HASH_REG_W-1:0] HASH_BITS_RESET = 4'd15;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic REG_HASH_BITS = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_INS,
		ST_FIN
	} state_t;

endpackage

// ----- design/bloom_prefiltered_id_set.sv -----
// Bloom-prefiltered ID set: one request at a time. After reset the filter bitmap, of
// 2**(MAX_HASH_BITS-3) bytes (4096 at the defaults), is swept to zero while in_ready stays
// low; APB writes are taken meanwhile. A query whose bitmap bit is clear passes from its
// accept through ST_LOOK to ST_FIN, and such an insert through ST_LOOK and ST_INS to ST_FIN.
// When the bit is set the stored IDs are scanned in ST_SCAN before ST_FIN, with ST_INS
// between for an insert of a new ID; a match ends the scan early. The ID table is a
// single-port memory read one entry per cycle into one 63-bit comparator. The result
// sits in an output register: a stalled result holds until out_ready, and the next
// request waits in ST_FIN for the register to free up.
module bloom_prefiltered_id_set #(
	parameter int MAX_IDS       = 1024,
	parameter int MAX_HASH_BITS = 15
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic [bpis_pkg::ID_W-1:0] id,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     member,
	output logic                     bitmap_hit,
	output logic                     dropped,
	// configuration
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int FAW = MAX_HASH_BITS - bpis_pkg::BYTE_SHIFT;
	localparam int FD  = 2 ** FAW;
	localparam int CW  = $clog2(MAX_IDS + 1);
	localparam int IW  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int HBW = $clog2(MAX_HASH_BITS + 1);

	bpis_pkg::state_t state_q, state_d;

	logic [bpis_pkg::HASH_REG_W-1:0] hash_q;
	logic [HBW-1:0]                  eff_hb;
	logic [MAX_HASH_BITS-1:0]        slot_mask;
	logic [MAX_HASH_BITS-1:0]        slot;

	logic [FAW-1:0]             clr_idx_q;
	logic                       kind_q;
	logic [bpis_pkg::ID_W-1:0]  id_q;
	logic [FAW-1:0]             byte_q;
	logic [2:0]                 bit_q;
	logic [7:0]                 fdata_q;
	logic                       hit;

	logic [CW-1:0]              count_q;
	logic [CW-1:0]              rd_idx_q;
	logic                       cmp_vld_q;
	logic [bpis_pkg::ID_W-1:0]  sdata_q;
	logic                       match;
	logic                       scan_done;
	logic                       room;

	logic                       hit_q;
	logic                       res_member_q;
	logic                       res_dropped_q;
	logic                       member_q;
	logic                       bitmap_hit_q;
	logic                       dropped_q;
	logic                       out_valid_q;

	logic                       fwr_en;
	logic [FAW-1:0]             fwr_addr;
	logic [7:0]                 fwr_data;
	logic                       srd_en;
	logic                       swr_en;
	logic                       out_load;

	logic [7:0]                 filter_mem [FD];
	logic [bpis_pkg::ID_W-1:0]  store_mem  [MAX_IDS];

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= bpis_pkg::HASH_BITS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == bpis_pkg::REG_HASH_BITS)) begin
			hash_q <= pwdata[bpis_pkg::HASH_REG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == bpis_pkg::REG_HASH_BITS) begin
			prdata[bpis_pkg::HASH_REG_W-1:0] = hash_q;
		end
	end

	// clamp the hash width and cut the slot from the incoming id
	always_comb begin
		if (int'(hash_q) < bpis_pkg::MIN_HASH_BITS) begin
			eff_hb = HBW'(bpis_pkg::MIN_HASH_BITS);
		end else if (int'(hash_q) > MAX_HASH_BITS) begin
			eff_hb = HBW'(MAX_HASH_BITS);
		end else begin
			eff_hb = HBW'(hash_q);
		end
		slot_mask = ~({MAX_HASH_BITS{1'b1}} << eff_hb);
		slot      = id[MAX_HASH_BITS-1:0] & slot_mask;
	end

	assign hit       = fdata_q[bit_q];
	assign match     = cmp_vld_q && (sdata_q == id_q);
	assign scan_done = !cmp_vld_q && (rd_idx_q == count_q);
	assign room      = count_q < CW'(MAX_IDS);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpis_pkg::ST_CLEAR: begin
				if (clr_idx_q == FAW'(FD - 1)) state_d = bpis_pkg::ST_IDLE;
			end
			bpis_pkg::ST_IDLE: begin
				if (in_valid) state_d = bpis_pkg::ST_LOOK;
			end
			bpis_pkg::ST_LOOK: begin
				priority if (hit) begin
					state_d = bpis_pkg::ST_SCAN;
				end else if (kind_q == bpis_pkg::KIND_QUERY) begin
					state_d = bpis_pkg::ST_FIN;
				end else begin
					state_d = bpis_pkg::ST_INS;
				end
			end
			bpis_pkg::ST_SCAN: begin
				priority if (match) begin
					state_d = bpis_pkg::ST_FIN;
				end else if (scan_done) begin
					state_d = (kind_q == bpis_pkg::KIND_QUERY) ? bpis_pkg::ST_FIN
					                                           : bpis_pkg::ST_INS;
				end
			end
			bpis_pkg::ST_INS: state_d = bpis_pkg::ST_FIN;
			bpis_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) state_d = bpis_pkg::ST_IDLE;
			end
			default: state_d = bpis_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		in_ready = 1'b0;
		fwr_en   = 1'b0;
		fwr_addr = clr_idx_q;
		fwr_data = 8'h00;
		srd_en   = 1'b0;
		swr_en   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			bpis_pkg::ST_CLEAR: fwr_en = 1'b1;
			bpis_pkg::ST_IDLE:  in_ready = 1'b1;
			bpis_pkg::ST_SCAN:  srd_en = !match && (rd_idx_q < count_q);
			bpis_pkg::ST_INS: begin
				fwr_en   = room;
				fwr_addr = byte_q;
				fwr_data = fdata_q | (8'h01 << bit_q);
				swr_en   = room;
			end
			bpis_pkg::ST_FIN:   out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// filter bitmap: one write and one read port, registered read
	always_ff @(posedge clk) begin
		if (fwr_en) filter_mem[fwr_addr] <= fwr_data;
		if (state_q == bpis_pkg::ST_IDLE) fdata_q <= filter_mem[slot[MAX_HASH_BITS-1:3]];
	end

	// ID table: single port, registered read
	always_ff @(posedge clk) begin
		if (swr_en) begin
			store_mem[count_q[IW-1:0]] <= id_q;
		end else if (srd_en) begin
			sdata_q <= store_mem[rd_idx_q[IW-1:0]];
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			id_q   <= id;
			byte_q <= slot[MAX_HASH_BITS-1:3];
			bit_q  <= slot[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bpis_pkg::ST_CLEAR;
			clr_idx_q     <= '0;
			count_q       <= '0;
			rd_idx_q      <= '0;
			cmp_vld_q     <= 1'b0;
			hit_q         <= 1'b0;
			res_member_q  <= 1'b0;
			res_dropped_q <= 1'b0;
			out_valid_q   <= 1'b0;
			member_q      <= 1'b0;
			bitmap_hit_q  <= 1'b0;
			dropped_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bpis_pkg::ST_CLEAR) clr_idx_q <= clr_idx_q + FAW'(1);
			if (state_q == bpis_pkg::ST_LOOK) begin
				hit_q         <= hit;
				res_member_q  <= 1'b0;
				res_dropped_q <= 1'b0;
				rd_idx_q      <= '0;
				cmp_vld_q     <= 1'b0;
			end
			if (state_q == bpis_pkg::ST_SCAN) begin
				// advance the read one entry ahead of the compare
				cmp_vld_q <= srd_en;
				if (srd_en) rd_idx_q <= rd_idx_q + CW'(1);
				if (match) res_member_q <= 1'b1;
			end
			if (state_q == bpis_pkg::ST_INS) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					res_dropped_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q  <= 1'b1;
				member_q     <= res_member_q;
				bitmap_hit_q <= hit_q;
				dropped_q    <= res_dropped_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign member     = member_q;
	assign bitmap_hit = bitmap_hit_q;
	assign dropped    = dropped_q;

endmodule
